[hw/rtl/dwr_pkg.sv]
// Shared types and constants for the death watch registry.
package dwr_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LIVE_W = 5;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		REQ_WATCH   = 3'd0,
		REQ_UNWATCH = 3'd1,
		REQ_RECV    = 3'd2,
		REQ_DEATH   = 3'd3,
		REQ_DRAIN   = 3'd4,
		REQ_COUNT   = 3'd5,
		REQ_QUERY   = 3'd6,
		REQ_CLEAR   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_FREE    = 2'd0,
		ST_ACTIVE  = 2'd1,
		ST_PENDING = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_SCAN  = 2'd1,
		BK_FINAL = 2'd2
	} bk_state_t;

	localparam logic KIND_FINAL = 1'b0;
	localparam logic KIND_POKE  = 1'b1;

	typedef struct packed {
		req_t        req;
		logic [63:0] actor_id;
		logic [31:0] actor_gen;
		logic [63:0] target_id;
		logic [63:0] sup_id;
		logic [31:0] target_gen;
		logic [31:0] sup_gen;
		logic [63:0] exit_status;
		logic        watch_ok;
	} cmd_t;

	typedef struct packed {
		logic      pop;
		logic      write_new;
		logic      latch;
		logic      poke;
		logic      set_status;
		slot_st_t  status;
		logic      take_rec;
		logic      found;
		logic      inc_live;
		logic      clear_all;
		logic      emit_final;
	} bk_ctl_t;

endpackage

[hw/rtl/dwr_front.sv]
// Front end: take a request transaction and classify it into a queued command.
module dwr_front
	import dwr_pkg::*;
(
	input  logic [2:0]  req_type,
	input  logic [63:0] actor_id,
	input  logic [31:0] actor_gen,
	input  logic [63:0] target_id,
	input  logic [63:0] supervisor_arg,
	input  logic        watched_live,
	input  logic [31:0] target_gen,
	input  logic        supervisor_live,
	input  logic [31:0] super_gen,
	input  logic [63:0] exit_status,
	output cmd_t        cmd
);

	logic [63:0] sup;

	always_comb begin
		sup = (supervisor_arg != 64'd0) ? supervisor_arg : actor_id;
		cmd.req = req_t'(req_type);
		cmd.actor_id = actor_id;
		cmd.actor_gen = actor_gen;
		cmd.target_id = target_id;
		cmd.sup_id = sup;
		cmd.target_gen = target_gen;
		cmd.sup_gen = super_gen;
		cmd.exit_status = exit_status;
		cmd.watch_ok = (actor_id == target_id || actor_id == sup) && sup != target_id &&
			watched_live && supervisor_live;
	end

endmodule

[hw/rtl/dwr_queue.sv]
// Two-entry command queue between the front end and the slot engine.
module dwr_queue
	import dwr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

[hw/rtl/dwr_back.sv]
// Slot engine: scan the watch table one slot a cycle and emit results.
module dwr_back
	import dwr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        q_head,
	output logic        q_pop,
	output logic        valid,
	output logic        result_kind,
	output logic        ok,
	output logic [63:0] dead_id,
	output logic [63:0] dead_exit,
	output logic        killed_by_signal,
	output logic [63:0] poke_id,
	output logic [31:0] poke_gen,
	output logic [4:0]  live_slots,
	output logic        last
);

	bk_state_t        state_q, state_nxt;
	bk_ctl_t          ctl;
	cmd_t             it_q;
	logic [IDX_W-1:0] idx_q;
	slot_st_t         st_q [SLOTS];
	logic [63:0]      wid_q [SLOTS];
	logic [31:0]      wgen_q [SLOTS];
	logic [63:0]      sid_q [SLOTS];
	logic [31:0]      sgen_q [SLOTS];
	logic [63:0]      exit_q [SLOTS];
	logic             sig_q [SLOTS];
	logic             acc_ok_q;
	logic [63:0]      acc_did_q;
	logic [63:0]      acc_dex_q;
	logic             acc_sig_q;
	logic [LIVE_W-1:0] acc_live_q;
	logic             valid_q, kind_q, ok_q, sig_out_q, last_q;
	logic [63:0]      did_q, dex_q, pid_q;
	logic [31:0]      pgen_q;
	logic [LIVE_W-1:0] live_q;

	slot_st_t cur;
	logic     nonfree, sup_m, w_m, dead_m, end_scan;

	always_comb begin
		cur = st_q[idx_q];
		nonfree = (cur != ST_FREE);
		sup_m = (sid_q[idx_q] == it_q.actor_id) && (sgen_q[idx_q] == it_q.actor_gen);
		w_m = (wid_q[idx_q] == it_q.target_id);
		dead_m = (cur == ST_ACTIVE) && (wid_q[idx_q] == it_q.actor_id) &&
			(wgen_q[idx_q] == it_q.actor_gen);
		end_scan = (idx_q == IDX_W'(SLOTS - 1));
	end

	always_comb begin
		ctl = '0;
		ctl.status = ST_FREE;
		case (state_q)
			BK_IDLE: begin
				ctl.pop = !q_empty;
			end
			BK_SCAN: begin
				case (it_q.req)
					REQ_WATCH: begin
						if (it_q.watch_ok && !nonfree) begin
							ctl.write_new = 1'b1;
							ctl.set_status = 1'b1;
							ctl.status = ST_ACTIVE;
							ctl.found = 1'b1;
						end
					end
					REQ_UNWATCH: begin
						ctl.set_status = nonfree && sup_m && w_m;
					end
					REQ_RECV: begin
						if (cur == ST_PENDING && sup_m) begin
							ctl.set_status = 1'b1;
							ctl.take_rec = 1'b1;
							ctl.found = 1'b1;
						end
					end
					REQ_DEATH: begin
						if (dead_m) begin
							ctl.latch = 1'b1;
							ctl.set_status = 1'b1;
							ctl.status = ST_PENDING;
							ctl.poke = (sid_q[idx_q] != it_q.actor_id);
						end
						if (nonfree && sup_m) begin
							ctl.set_status = 1'b1;
							ctl.status = ST_FREE;
						end
					end
					REQ_DRAIN: begin
						ctl.set_status = nonfree && sup_m;
					end
					REQ_COUNT: begin
						ctl.inc_live = nonfree;
					end
					REQ_QUERY: begin
						ctl.found = nonfree && sup_m && w_m;
					end
					default: begin
						ctl.clear_all = 1'b1;
					end
				endcase
			end
			BK_FINAL: begin
				ctl.emit_final = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_nxt = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (end_scan || ctl.found || ctl.clear_all) begin
					state_nxt = BK_FINAL;
				end
			end
			BK_FINAL: begin
				state_nxt = BK_IDLE;
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	assign q_pop = ctl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q <= '0;
			valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				st_q[i] <= ST_FREE;
			end
		end else begin
			state_q <= state_nxt;
			valid_q <= ctl.poke || ctl.emit_final;
			if (ctl.pop) begin
				idx_q <= '0;
			end else if (state_q == BK_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.set_status) begin
				st_q[idx_q] <= ctl.status;
			end
			if (ctl.clear_all) begin
				for (int i = 0; i < SLOTS; i++) begin
					st_q[i] <= ST_FREE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			it_q <= q_head;
			acc_ok_q <= 1'b0;
			acc_did_q <= '0;
			acc_dex_q <= '0;
			acc_sig_q <= 1'b0;
			acc_live_q <= '0;
		end
		if (ctl.write_new) begin
			wid_q[idx_q] <= it_q.target_id;
			wgen_q[idx_q] <= it_q.target_gen;
			sid_q[idx_q] <= it_q.sup_id;
			sgen_q[idx_q] <= it_q.sup_gen;
			exit_q[idx_q] <= '0;
			sig_q[idx_q] <= 1'b0;
		end
		if (ctl.latch) begin
			exit_q[idx_q] <= it_q.exit_status;
			sig_q[idx_q] <= it_q.exit_status[63];
		end
		if (ctl.found) begin
			acc_ok_q <= 1'b1;
		end
		if (ctl.take_rec) begin
			acc_did_q <= wid_q[idx_q];
			acc_dex_q <= exit_q[idx_q];
			acc_sig_q <= sig_q[idx_q];
		end
		if (ctl.inc_live) begin
			acc_live_q <= acc_live_q + 1'b1;
		end
		if (ctl.poke) begin
			kind_q <= KIND_POKE;
			ok_q <= 1'b0;
			did_q <= '0;
			dex_q <= '0;
			sig_out_q <= 1'b0;
			pid_q <= sid_q[idx_q];
			pgen_q <= sgen_q[idx_q];
			live_q <= '0;
			last_q <= 1'b0;
		end else if (ctl.emit_final) begin
			kind_q <= KIND_FINAL;
			ok_q <= acc_ok_q;
			did_q <= acc_did_q;
			dex_q <= acc_dex_q;
			sig_out_q <= acc_sig_q;
			pid_q <= '0;
			pgen_q <= '0;
			live_q <= acc_live_q;
			last_q <= 1'b1;
		end
	end

	assign valid = valid_q;
	assign result_kind = kind_q;
	assign ok = ok_q;
	assign dead_id = did_q;
	assign dead_exit = dex_q;
	assign killed_by_signal = sig_out_q;
	assign poke_id = pid_q;
	assign poke_gen = pgen_q;
	assign live_slots = live_q;
	assign last = last_q;

endmodule

[hw/rtl/death_watch_registry.sv]
// Top level of the death watch registry: front end, command queue, slot engine.
//
//  channel   direction  handshake          payload
//  request   in         start & !busy      req_type .. exit_status
//  result    out        valid (one cycle)  result_kind .. last
//
// A request passes the front end and the queue, then the slot engine scans up to SLOTS
// slots (one slot a cycle; watch, recv and query stop at the first hit, clear stops
// at the first slot) and then emits the final status. Pokes leave during the scan,
// one per cycle. busy rises when the two-entry queue is full. Reset frees all slots
// at once; the receiver cannot stall results.
module death_watch_registry
	import dwr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [63:0] actor_id,
	input  logic [31:0] actor_gen,
	input  logic [63:0] target_id,
	input  logic [63:0] supervisor_arg,
	input  logic        watched_live,
	input  logic [31:0] target_gen,
	input  logic        supervisor_live,
	input  logic [31:0] super_gen,
	input  logic [63:0] exit_status,
	output logic        valid,
	output logic        result_kind,
	output logic        ok,
	output logic [63:0] dead_id,
	output logic [63:0] dead_exit,
	output logic        killed_by_signal,
	output logic [63:0] poke_id,
	output logic [31:0] poke_gen,
	output logic [4:0]  live_slots,
	output logic        last
);

	cmd_t cmd, head;
	logic full, empty, pop, push;

	assign busy = full;
	assign push = start && !full;

	dwr_front u_front (
		.req_type(req_type), .actor_id(actor_id), .actor_gen(actor_gen),
		.target_id(target_id), .supervisor_arg(supervisor_arg),
		.watched_live(watched_live), .target_gen(target_gen),
		.supervisor_live(supervisor_live), .super_gen(super_gen),
		.exit_status(exit_status), .cmd(cmd)
	);

	dwr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(cmd), .full(full),
		.pop(pop), .empty(empty), .head(head)
	);

	dwr_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(empty), .q_head(head), .q_pop(pop),
		.valid(valid), .result_kind(result_kind), .ok(ok), .dead_id(dead_id),
		.dead_exit(dead_exit), .killed_by_signal(killed_by_signal),
		.poke_id(poke_id), .poke_gen(poke_gen), .live_slots(live_slots), .last(last)
	);

`ifndef SYNTH
	a_poke_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind |-> !last && !ok && live_slots == 5'd0)
		else $error("poke marked as final");
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result_kind |-> last && poke_id == 64'd0)
		else $error("final status without last");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("result directly after final status");
`endif

endmodule
